FILE: hdl/salc_pkg.sv
// Shared constants and codes of the set-associative LRU cache tag store.
package salc_pkg;

  localparam int SET_CFG_W  = 3;
  localparam int WAY_CFG_W  = 4;
  localparam int OFF_CFG_W  = 5;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_ADDR_W  = 32;
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int CNT_W      = 32;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_PAD_W  = OUT_DATA_W - 2 - 3 * CNT_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_STORE  = 2'd1;
  localparam logic [1:0] ACT_MODIFY = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

endpackage

FILE: hdl/salc_set_update.sv
// Lookup, victim choice and LRU age update of one set row.
module salc_set_update #(
  parameter int MAX_WAYS = 8,
  parameter int TAG_W    = 32,
  parameter int AGE_W    = 3,
  parameter int WAY_W    = 3,
  parameter int WCNT_W   = 4
) (
  input  logic [WCNT_W-1:0]               ways,
  input  logic [TAG_W-1:0]                tag,
  input  logic [MAX_WAYS-1:0]             valid_i,
  input  logic [MAX_WAYS-1:0][AGE_W-1:0]  age_i,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_i,
  output logic [MAX_WAYS-1:0]             valid_o,
  output logic [MAX_WAYS-1:0][AGE_W-1:0]  age_o,
  output logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_o,
  output logic [1:0]                      outcome
);
  import salc_pkg::*;

  localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0] used;
  logic [MAX_WAYS-1:0] hit;
  logic [MAX_WAYS-1:0] free;
  logic [MAX_WAYS-1:0] bump;
  logic                hit_any;
  logic                free_any;
  logic [WAY_W-1:0]    hit_idx;
  logic [WAY_W-1:0]    free_idx;
  logic [WAY_W-1:0]    old_idx;
  logic [WAY_W-1:0]    pick;
  logic [AGE_W-1:0]    hit_age;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      used[w] = (WCNT_W'(w) < ways);
      hit[w]  = used[w] && valid_i[w] && (tag_i[w] == tag);
      free[w] = used[w] && !valid_i[w];
    end
  end

  always_comb begin
    hit_any  = |hit;
    free_any = |free;
    hit_idx  = '0;
    free_idx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit[w]) begin
        hit_idx = WAY_W'(w);
      end
      if (free[w]) begin
        free_idx = WAY_W'(w);
      end
    end
    old_idx = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (used[w] && (age_i[w] > age_i[old_idx])) begin
        old_idx = WAY_W'(w);
      end
    end
  end

  assign hit_age = age_i[hit_idx];
  assign pick    = hit_any ? hit_idx : (free_any ? free_idx : old_idx);
  assign outcome = hit_any ? OUT_HIT : (free_any ? OUT_FILL : OUT_EVICT);

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      valid_o[w] = valid_i[w];
      tag_o[w]   = tag_i[w];
      age_o[w]   = age_i[w];
      bump[w]    = used[w] && valid_i[w] && (WAY_W'(w) != pick) &&
                   (!hit_any || (age_i[w] < hit_age));
      if (bump[w] && (age_i[w] != AGE_TOP)) begin
        age_o[w] = age_i[w] + 1'b1;
      end
      if (WAY_W'(w) == pick) begin
        age_o[w] = '0;
        if (!hit_any) begin
          valid_o[w] = 1'b1;
          tag_o[w]   = tag;
        end
      end
    end
  end

endmodule

FILE: hdl/set_assoc_lru_cache_tag_model.sv
// Top level of the set-associative LRU cache tag store with its set-row memory.
// An accepted load, store or modify reads its set row into a register; the lookup
// state writes the row back and registers the result word once the output can take
// it, a second time on the row just written for a modify. in_tready is low until
// the last word is registered. Synchronous active-low reset clears counters and
// per-set row valid flags and resets configuration at once; no clearing pass runs.
module set_assoc_lru_cache_tag_model #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_BITS    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [salc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [salc_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // address
  input  logic [salc_pkg::IN_DATA_W-1:0]    in_tdata,
  // action
  input  logic [salc_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // outcome, hits_so_far, misses_so_far, evictions_so_far, zero padding
  output logic [salc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import salc_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int TAG_W    = (ADDR_BITS < IN_ADDR_W) ? ADDR_BITS : IN_ADDR_W;
  localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W    = AGE_W;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int ROW_W    = MAX_WAYS * (1 + AGE_W + TAG_W);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic                 state_r, state_nxt;
  logic                 second_r, second_nxt;
  logic                 modify_r, modify_nxt;
  logic [SET_CFG_W-1:0] cfg_set_r;
  logic [WAY_CFG_W-1:0] cfg_ways_r;
  logic [OFF_CFG_W-1:0] cfg_off_r;
  logic [CNT_W-1:0]     hit_r, miss_r, evict_r;
  logic [CNT_W-1:0]     hit_nxt, miss_nxt, evict_nxt;
  logic                 out_tvalid_r, out_tlast_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [ROW_W-1:0]     mem [NUM_SETS];
  logic [NUM_SETS-1:0]  row_init_r;
  logic [ROW_W-1:0]     rd_row_r;
  logic                 rd_init_r;
  logic [ROW_W-1:0]     fwd_r;
  logic [SET_W-1:0]     set_r;
  logic [TAG_W-1:0]     tag_r;

  logic                 in_acc;
  logic                 rd_en;
  logic                 go;
  logic                 mem_we;
  logic [TAG_W-1:0]     addr_w;
  logic [TAG_W-1:0]     shifted;
  logic [TAG_W-1:0]     set_mask;
  logic [TAG_W-1:0]     set_full;
  logic [SET_W-1:0]     set_idx;
  logic [TAG_W-1:0]     tag_in;
  logic [SET_CFG_W-1:0] sbits;
  logic [WCNT_W-1:0]    ways_eff;

  logic [ROW_W-1:0]                src_row;
  logic                            src_init;
  logic [MAX_WAYS-1:0]             src_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]  src_age;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  src_tag;
  logic [MAX_WAYS-1:0]             cur_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]  cur_age;
  logic [MAX_WAYS-1:0]             new_valid;
  logic [MAX_WAYS-1:0][AGE_W-1:0]  new_age;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tag;
  logic [ROW_W-1:0]                row_wr;
  logic [1:0]                      upd_outcome;

  // Address split and way clamp.
  assign addr_w   = in_tdata[TAG_W-1:0];
  assign shifted  = addr_w >> cfg_off_r;
  assign sbits    = (int'(cfg_set_r) > MAX_SET_BITS) ? SET_CFG_W'(MAX_SET_BITS) : cfg_set_r;
  assign set_mask = (TAG_W'(1) << sbits) - TAG_W'(1);
  assign set_full = shifted & set_mask;
  assign set_idx  = set_full[SET_W-1:0];
  assign tag_in   = shifted >> sbits;

  always_comb begin
    if (cfg_ways_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(cfg_ways_r) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(cfg_ways_r);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign rd_en     = in_acc && (in_tuser != ACT_NONE);
  assign go        = !out_tvalid_r || out_tready;
  assign mem_we    = (state_r == S_LOOK) && go;

  // Second pass of a modify works on the row just written.
  assign src_row   = second_r ? fwd_r : rd_row_r;
  assign src_init  = second_r || rd_init_r;
  assign {src_valid, src_age, src_tag} = src_row;
  assign cur_valid = src_init ? src_valid : '0;
  assign cur_age   = src_init ? src_age : '0;

  salc_set_update #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .AGE_W    (AGE_W),
    .WAY_W    (WAY_W),
    .WCNT_W   (WCNT_W)
  ) u_update (
    .ways    (ways_eff),
    .tag     (tag_r),
    .valid_i (cur_valid),
    .age_i   (cur_age),
    .tag_i   (src_tag),
    .valid_o (new_valid),
    .age_o   (new_age),
    .tag_o   (new_tag),
    .outcome (upd_outcome)
  );

  assign row_wr    = {new_valid, new_age, new_tag};
  assign hit_nxt   = hit_r + CNT_W'(upd_outcome == OUT_HIT);
  assign miss_nxt  = miss_r + CNT_W'(upd_outcome != OUT_HIT);
  assign evict_nxt = evict_r + CNT_W'(upd_outcome == OUT_EVICT);

  always_comb begin
    state_nxt  = state_r;
    second_nxt = second_r;
    modify_nxt = modify_r;
    unique case (state_r)
      S_IDLE: begin
        if (rd_en) begin
          state_nxt  = S_LOOK;
          second_nxt = 1'b0;
          modify_nxt = (in_tuser == ACT_MODIFY);
        end
      end
      S_LOOK: begin
        if (go) begin
          if (modify_r && !second_r) begin
            second_nxt = 1'b1;
          end else begin
            state_nxt  = S_IDLE;
            second_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[set_r] <= row_wr;
    end
    if (rd_en) begin
      rd_row_r <= mem[set_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_init_r <= row_init_r[set_idx];
      set_r     <= set_idx;
      tag_r     <= tag_in;
    end
    if (mem_we) begin
      fwd_r       <= row_wr;
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, evict_nxt, miss_nxt, hit_nxt, upd_outcome};
      out_tlast_r <= !modify_r || second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      second_r     <= 1'b0;
      modify_r     <= 1'b0;
      cfg_set_r    <= '0;
      cfg_ways_r   <= WAY_CFG_W'(1);
      cfg_off_r    <= '0;
      hit_r        <= '0;
      miss_r       <= '0;
      evict_r      <= '0;
      out_tvalid_r <= 1'b0;
      row_init_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
      modify_r <= modify_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SET_BITS: cfg_set_r  <= cfg_wdata[SET_CFG_W-1:0];
          CFG_WAYS:     cfg_ways_r <= cfg_wdata[WAY_CFG_W-1:0];
          CFG_OFFSET:   cfg_off_r  <= cfg_wdata[OFF_CFG_W-1:0];
          default: ;
        endcase
      end
      if (mem_we) begin
        hit_r              <= hit_nxt;
        miss_r             <= miss_nxt;
        evict_r            <= evict_nxt;
        row_init_r[set_r]  <= 1'b1;
        out_tvalid_r       <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  assert property (@(posedge clk) disable iff (!rst_n) second_r |-> modify_r)
    else $error("second pass without a modify access");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && second_r) |-> (upd_outcome == OUT_HIT))
    else $error("second pass of a modify did not hit");

  assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(miss_r) |-> $past(state_r == S_LOOK))
    else $error("miss count changed outside a lookup");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK && go && second_r) |=> (out_tvalid && out_tlast))
    else $error("final word of a modify not marked last");

endmodule

FILE: bench/set_assoc_lru_cache_tag_model_tb.sv
// Self-checking bench for the set-associative LRU cache tag store, with an LRU scoreboard.
`timescale 1ns / 100ps

module set_assoc_lru_cache_tag_model_tb;
  import salc_pkg::*;

  localparam int LINE_WAYS   = 8;
  localparam int SET_LIMIT   = 6;
  localparam int LINE_COUNT  = (1 << SET_LIMIT) * LINE_WAYS;
  localparam int AGE_TOP     = LINE_WAYS - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 135;
  localparam int PHASE_COUNT = 8;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]       outcome;
    logic             last;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } access_result_t;

  class lru_tag_scoreboard;
    bit               line_valid [LINE_COUNT];
    logic [31:0]      line_tag   [LINE_COUNT];
    bit [2:0]         line_age   [LINE_COUNT];
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] evict_count;
    logic [SET_CFG_W-1:0] set_bits;
    logic [WAY_CFG_W-1:0] way_count;
    logic [OFF_CFG_W-1:0] offset_bits;
    access_result_t expected_results [$];
    int errors;

    function new();
      foreach (line_valid[i]) begin
        line_valid[i] = 1'b0;
        line_age[i]   = '0;
      end
      hit_count   = '0;
      miss_count  = '0;
      evict_count = '0;
      set_bits    = '0;
      way_count   = 4'd1;
      offset_bits = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_SET_BITS: set_bits    = value[SET_CFG_W-1:0];
        CFG_WAYS:     way_count   = value[WAY_CFG_W-1:0];
        CFG_OFFSET:   offset_bits = value[OFF_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function void age_line(int idx);
      if (line_age[idx] < AGE_TOP) line_age[idx] = line_age[idx] + 3'd1;
    endfunction

    function logic [1:0] look_up_line(logic [31:0] addr);
      int sbits, nways, base, pick, w, k;
      logic [31:0] shifted, tag_value;
      bit [2:0] hit_age;
      logic [1:0] outcome;
      sbits = (set_bits > SET_LIMIT) ? SET_LIMIT : int'(set_bits);
      nways = (way_count == 0) ? 1 : (way_count > LINE_WAYS) ? LINE_WAYS : int'(way_count);
      shifted = addr >> offset_bits;
      base = int'(shifted & ((32'd1 << sbits) - 32'd1)) * LINE_WAYS;
      tag_value = shifted >> sbits;
      for (w = 0; w < nways; w++) begin
        if (line_valid[base + w] && line_tag[base + w] == tag_value) begin
          hit_age = line_age[base + w];
          for (k = 0; k < nways; k++)
            if (k != w && line_valid[base + k] && line_age[base + k] < hit_age)
              age_line(base + k);
          line_age[base + w] = '0;
          hit_count++;
          return OUT_HIT;
        end
      end
      miss_count++;
      pick = nways;
      for (w = 0; w < nways; w++) begin
        if (!line_valid[base + w]) begin
          pick = w;
          break;
        end
      end
      if (pick == nways) begin
        pick = 0;
        for (w = 1; w < nways; w++)
          if (line_age[base + w] > line_age[base + pick]) pick = w;
      end
      outcome = line_valid[base + pick] ? OUT_EVICT : OUT_FILL;
      for (w = 0; w < nways; w++)
        if (w != pick && line_valid[base + w]) age_line(base + w);
      line_valid[base + pick] = 1'b1;
      line_tag[base + pick]   = tag_value;
      line_age[base + pick]   = '0;
      if (outcome == OUT_EVICT) evict_count++;
      return outcome;
    endfunction

    function void push_result(logic [1:0] outcome, logic last);
      access_result_t r;
      r.outcome   = outcome;
      r.last      = last;
      r.hits      = hit_count;
      r.misses    = miss_count;
      r.evictions = evict_count;
      expected_results.push_back(r);
    endfunction

    function void note_access(logic [1:0] action, logic [31:0] addr);
      logic [1:0] outcome;
      if (action == ACT_NONE) return;
      outcome = look_up_line(addr);
      push_result(outcome, action != ACT_MODIFY);
      if (action == ACT_MODIFY) begin
        outcome = look_up_line(addr);
        push_result(outcome, 1'b1);
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
      access_result_t exp;
      if (expected_results.size() == 0) begin
        $error("Result word arrived with none expected: tdata %h", data);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (data[1:0] !== exp.outcome) begin
        $error("outcome: expected %0d, actual %0d", exp.outcome, data[1:0]);
        errors++;
      end
      if (last !== exp.last) begin
        $error("last_of_run: expected %0d, actual %0d", exp.last, last);
        errors++;
      end
      if (data[2 +: CNT_W] !== exp.hits) begin
        $error("hits_so_far: expected %0d, actual %0d", exp.hits, data[2 +: CNT_W]);
        errors++;
      end
      if (data[2 + CNT_W +: CNT_W] !== exp.misses) begin
        $error("misses_so_far: expected %0d, actual %0d", exp.misses,
               data[2 + CNT_W +: CNT_W]);
        errors++;
      end
      if (data[2 + 2 * CNT_W +: CNT_W] !== exp.evictions) begin
        $error("evictions_so_far: expected %0d, actual %0d", exp.evictions,
               data[2 + 2 * CNT_W +: CNT_W]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  // address
  logic [IN_DATA_W-1:0]  in_tdata;
  // action
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // outcome, hits_so_far, misses_so_far, evictions_so_far, zero padding
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  lru_tag_scoreboard sb;
  int cycle_count;
  int n_accepted;
  int hold_left;
  bit hold_done;
  int stall_mode;
  int mode_left;

  set_assoc_lru_cache_tag_model uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // The receiver stalls on patterns of its own and, once, holds off for a long stretch.
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    hold_done  = 1'b0;
    stall_mode = 0;
    mode_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && n_accepted >= 500) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= cycle_count[1];
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    sb.write_reg(idx, value[CFG_W-1:0]);
  endtask

  task automatic configure(input int set_bits, input int ways, input int offset);
    write_reg(CFG_SET_BITS, set_bits);
    write_reg(CFG_WAYS, ways);
    write_reg(CFG_OFFSET, offset);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_access(input logic [1:0] action, input logic [31:0] addr);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= addr;
    do @(posedge clk); while (!in_tready);
    sb.note_access(action, addr);
    n_accepted++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic wait_quiet();
    idle_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Addresses mostly fall on a few sets and a few tags so that hits and evictions are common.
  function automatic logic [31:0] pick_address(int set_bits, int ways, int offset,
                                               int set_lo, logic [31:0] tag_base);
    int sbits;
    logic [63:0] a;
    logic [63:0] set_part;
    sbits = (set_bits > SET_LIMIT) ? SET_LIMIT : set_bits;
    if ($urandom_range(0, 9) == 0) return $urandom;
    set_part = 64'((set_lo + $urandom_range(0, 3)) & ((1 << sbits) - 1));
    a = (64'(tag_base + $urandom_range(0, ways + 2)) << (sbits + offset))
        | (set_part << offset)
        | (64'($urandom) & ((64'd1 << offset) - 64'd1));
    return a[31:0];
  endfunction

  function automatic logic [1:0] pick_action();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return ACT_NONE;
    if (r < 8) return ACT_LOAD;
    if (r < 14) return ACT_STORE;
    return ACT_MODIFY;
  endfunction

  int ph_sets [PHASE_COUNT] = '{2, 6, 7, 0, 3, 1, 5, 4};
  int ph_ways [PHASE_COUNT] = '{4, 8, 15, 0, 2, 9, 3, 1};
  int ph_off  [PHASE_COUNT] = '{4, 0, 31, 24, 5, 2, 6, 16};

  initial begin
    int p, sent, burst_left, set_lo, eff_ways;
    logic [31:0] tag_base;
    logic [1:0] action;
    sb          = new();
    cycle_count = 0;
    n_accepted  = 0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = ACT_LOAD;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: one set of one way, no offset.
    send_access(ACT_LOAD, 32'h0000_0000);
    send_access(ACT_LOAD, 32'h0000_0000);
    send_access(ACT_STORE, 32'hFFFF_FFFF);
    send_access(ACT_MODIFY, 32'hFFFF_FFFF);
    send_access(ACT_MODIFY, 32'h1234_5678);
    send_access(ACT_NONE, 32'h0000_0000);
    send_access(ACT_LOAD, 32'h0000_0000);
    wait_quiet();

    // Out-of-range set bits and ways, an offset that leaves only the top address bit.
    configure(7, 15, 31);
    send_access(ACT_LOAD, 32'h0000_0000);
    send_access(ACT_LOAD, 32'h8000_0000);
    send_access(ACT_LOAD, 32'hFFFF_FFFF);
    send_access(ACT_STORE, 32'h7FFF_FFFF);
    send_access(ACT_MODIFY, 32'h0000_0000);
    wait_quiet();

    // Two ways in one set: fills, LRU evictions, then a shrink to one way.
    configure(1, 2, 0);
    send_access(ACT_LOAD, 32'h0000_0000);
    send_access(ACT_LOAD, 32'h0000_0002);
    send_access(ACT_LOAD, 32'h0000_0004);
    send_access(ACT_LOAD, 32'h0000_0002);
    send_access(ACT_LOAD, 32'h0000_0000);
    wait_quiet();
    configure(1, 0, 0);
    send_access(ACT_MODIFY, 32'h0000_0002);
    send_access(ACT_LOAD, 32'h0000_0000);
    wait_quiet();

    for (p = 0; p < PHASE_COUNT; p++) begin
      configure(ph_sets[p], ph_ways[p], ph_off[p]);
      eff_ways   = (ph_ways[p] == 0) ? 1 : (ph_ways[p] > LINE_WAYS) ? LINE_WAYS : ph_ways[p];
      set_lo     = $urandom_range(0, 63);
      tag_base   = $urandom_range(0, 1) ? 32'd0 : $urandom;
      sent       = 0;
      burst_left = $urandom_range(1, 20);
      while (sent < PHASE_ITEMS) begin
        action = pick_action();
        send_access(action, pick_address(ph_sets[p], eff_ways, ph_off[p], set_lo, tag_base));
        if (action != ACT_NONE) sent++;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          if (p != 1) idle_cycles($urandom_range(1, 6));
        end
      end
      wait_quiet();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
